// ===== rtl/assert_macros.svh =====
// Assertion macros used by the core RTL file of the hash index.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CPHI_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CPHI_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cphi_pkg.sv =====
// Shared types and constants of the chained page hash index.
package cphi_pkg;

  localparam int DEF_MAX_BUCKETS      = 64;
  localparam int DEF_MAX_PAGE_ENTRIES = 8;
  localparam int DEF_POOL_PAGES       = 256;

  localparam logic [31:0] HASH_MUL = 32'd2654435761;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_CAP   = 2'd1;

  localparam logic [6:0] BUCKET_COUNT_RST = 7'd64;
  localparam logic [3:0] BUCKET_CAP_RST   = 4'd8;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_INVALID   = 3'd3;
  localparam logic [2:0] ST_NO_FREE   = 3'd4;

  typedef enum logic [1:0] {
    OP_SEARCH,
    OP_INSERT,
    OP_REMOVE,
    OP_UPDATE
  } op_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_MODGO,
    S_MOD,
    S_PG_RD,
    S_PG_WT,
    S_ENT_RD,
    S_ENT_CMP,
    S_PG_END,
    S_EXEC,
    S_POP,
    S_LINK,
    S_MOVE,
    S_RMV,
    S_UNLINK,
    S_DONE
  } state_t;

endpackage

// ===== rtl/cphi_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module cphi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/cphi_mod.sv =====
// Bit-serial remainder unit that reduces a 32-bit hash by the bucket count.
module cphi_mod #(
  parameter int DIV_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [31:0]      dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] rem
);
  logic [31:0]      dq;
  logic [5:0]       cnt;
  logic             busy;
  logic [DIV_W:0]   trial;
  logic [DIV_W-1:0] rem_next;

  always_comb begin
    trial = {rem, dq[31]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = DIV_W'(trial - {1'b0, divisor});
    end else begin
      rem_next = trial[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
    end else if (busy) begin
      dq  <= {dq[30:0], 1'b0};
      rem <= rem_next;
    end
  end
endmodule

// ===== rtl/chained_page_hash_index_core.sv =====
// Top level of the chained page hash index: sequencer, registers and memories.
// Sequence: hash and start the remainder, run the bit-serial remainder, read each chain
// page in turn and compare its entries, update the page, entry and free memories, then
// present the result. A held result keeps the sequencer in its last state.
// One request at a time; the next is taken in the idle cycle after the result is registered.
// Reset is synchronous; a clearing pass over all POOL_PAGES pages then sets up the page table.
`include "assert_macros.svh"

module chained_page_hash_index_core #(
  parameter int MAX_BUCKETS      = cphi_pkg::DEF_MAX_BUCKETS,
  parameter int MAX_PAGE_ENTRIES = cphi_pkg::DEF_MAX_PAGE_ENTRIES,
  parameter int POOL_PAGES       = cphi_pkg::DEF_POOL_PAGES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      opcode,
  input  logic signed [31:0]              key,
  input  logic [31:0]                     rec_page,
  input  logic [15:0]                     rec_slot,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      status,
  output logic [31:0]                     found_page,
  output logic [15:0]                     found_slot,
  output logic [11:0]                     total_entries,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cphi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cphi_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cphi_pkg::*;

  localparam int NUM_PRIMARY = (MAX_BUCKETS < POOL_PAGES) ? MAX_BUCKETS : POOL_PAGES;
  localparam int PW        = $clog2(POOL_PAGES);
  localparam int NW        = $clog2(POOL_PAGES + 1);
  localparam int FW        = $clog2(MAX_PAGE_ENTRIES + 1);
  localparam int BW        = $clog2(NUM_PRIMARY + 1);
  localparam int EDEPTH    = POOL_PAGES * MAX_PAGE_ENTRIES;
  localparam int EAW       = $clog2(EDEPTH);
  localparam int PGW       = FW + NW;
  localparam int ENTW      = 80;
  localparam int FREE_INIT = POOL_PAGES - NUM_PRIMARY;
  localparam logic [NW-1:0] NO_LINK = NW'(POOL_PAGES);

  state_t state, state_next;

  logic [6:0]    num_buckets;
  logic [3:0]    page_cap;
  logic [BW-1:0] ubkt;
  logic [FW-1:0] ucap;

  op_t           req_op;
  logic [31:0]   req_key;
  logic [47:0]   req_rec;
  logic [31:0]   hash;
  logic [PW-1:0] cur;
  logic [FW-1:0] cur_fill;
  logic [NW-1:0] cur_next;
  logic [FW-1:0] idx;
  logic          room_valid;
  logic [PW-1:0] room_pg;
  logic [FW-1:0] room_fill;
  logic [NW-1:0] room_next;
  logic          prev_valid;
  logic [PW-1:0] prev_pg;
  logic [FW-1:0] prev_fill;
  logic          hit;
  logic [47:0]   hit_rec;
  logic [PW-1:0] new_pg;
  logic [NW-1:0] free_top;
  logic [NW-1:0] ft_dec;
  logic [11:0]   stored;
  logic [2:0]    res_status;
  logic [PW-1:0] clr_ix;
  logic [FW-1:0] lastix;
  logic          unlink;

  logic            ent_we;
  logic [EAW-1:0]  ent_waddr, ent_raddr;
  logic [ENTW-1:0] ent_wdata, ent_rdata;
  logic            pg_we;
  logic [PW-1:0]   pg_waddr, pg_raddr;
  logic [PGW-1:0]  pg_wdata, pg_rdata;
  logic            fr_we;
  logic [PW-1:0]   fr_waddr, fr_raddr;
  logic [PW-1:0]   fr_wdata, fr_rdata;
  logic [FW-1:0]   pg_rfill;
  logic [NW-1:0]   pg_rnext;

  logic          mod_start, mod_done;
  logic [BW-1:0] mod_rem;

  function automatic logic [EAW-1:0] ent_addr(input logic [PW-1:0] pg,
                                              input logic [FW-1:0] ix);
    ent_addr = EAW'(EAW'(pg) * EAW'(MAX_PAGE_ENTRIES)) + EAW'(ix);
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign pg_rfill  = pg_rdata[PGW-1:NW];
  assign pg_rnext  = pg_rdata[NW-1:0];
  assign lastix    = cur_fill - 1'b1;
  assign unlink    = (lastix == '0) && prev_valid;
  assign ft_dec    = free_top - 1'b1;
  assign mod_start = (state == S_MODGO);

  always_comb begin
    if (num_buckets == '0) begin
      ubkt = BW'(1);
    end else if (32'(num_buckets) > NUM_PRIMARY) begin
      ubkt = BW'(NUM_PRIMARY);
    end else begin
      ubkt = BW'(num_buckets);
    end
    if (page_cap == '0) begin
      ucap = FW'(1);
    end else if (32'(page_cap) > MAX_PAGE_ENTRIES) begin
      ucap = FW'(MAX_PAGE_ENTRIES);
    end else begin
      ucap = FW'(page_cap);
    end
  end

  cphi_mod #(.DIV_W(BW)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (hash),
    .divisor  (ubkt),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  cphi_ram #(.WIDTH(ENTW), .DEPTH(EDEPTH)) u_entries (
    .clk (clk), .we (ent_we), .waddr (ent_waddr), .wdata (ent_wdata),
    .raddr (ent_raddr), .rdata (ent_rdata)
  );

  cphi_ram #(.WIDTH(PGW), .DEPTH(POOL_PAGES)) u_pages (
    .clk (clk), .we (pg_we), .waddr (pg_waddr), .wdata (pg_wdata),
    .raddr (pg_raddr), .rdata (pg_rdata)
  );

  cphi_ram #(.WIDTH(PW), .DEPTH(POOL_PAGES)) u_free (
    .clk (clk), .we (fr_we), .waddr (fr_waddr), .wdata (fr_wdata),
    .raddr (fr_raddr), .rdata (fr_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_ix == PW'(POOL_PAGES - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_HASH;
      end
      S_HASH: begin
        if ((req_op == OP_INSERT || req_op == OP_UPDATE) && (&req_rec[47:16])) begin
          state_next = S_DONE;
        end else begin
          state_next = S_MODGO;
        end
      end
      S_MODGO: state_next = S_MOD;
      S_MOD: begin
        if (mod_done) state_next = S_PG_RD;
      end
      S_PG_RD: state_next = S_PG_WT;
      S_PG_WT: begin
        state_next = (pg_rfill == '0) ? S_PG_END : S_ENT_RD;
      end
      S_ENT_RD: state_next = S_ENT_CMP;
      S_ENT_CMP: begin
        if (ent_rdata[79:48] == req_key) begin
          state_next = S_EXEC;
        end else if (FW'(idx + 1'b1) == cur_fill) begin
          state_next = S_PG_END;
        end else begin
          state_next = S_ENT_RD;
        end
      end
      S_PG_END: begin
        state_next = (cur_next >= NO_LINK) ? S_EXEC : S_PG_RD;
      end
      S_EXEC: begin
        unique case (req_op)
          OP_INSERT: begin
            if (hit || room_valid || free_top == '0) state_next = S_DONE;
            else state_next = S_POP;
          end
          OP_REMOVE: begin
            if (!hit) state_next = S_DONE;
            else if (idx != lastix) state_next = S_MOVE;
            else state_next = S_RMV;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_POP:    state_next = S_LINK;
      S_LINK:   state_next = S_DONE;
      S_MOVE:   state_next = S_RMV;
      S_RMV:    state_next = unlink ? S_UNLINK : S_DONE;
      S_UNLINK: state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = '0;
    ent_wdata = {req_key, req_rec};
    ent_raddr = ent_addr(cur, idx);
    pg_we     = 1'b0;
    pg_waddr  = cur;
    pg_wdata  = {cur_fill, cur_next};
    pg_raddr  = cur;
    fr_we     = 1'b0;
    fr_waddr  = free_top[PW-1:0];
    fr_wdata  = cur;
    fr_raddr  = ft_dec[PW-1:0];
    unique case (state)
      S_CLEAR: begin
        pg_we    = 1'b1;
        pg_waddr = clr_ix;
        pg_wdata = {FW'(0), NO_LINK};
        fr_we    = 1'b1;
        fr_waddr = clr_ix;
        fr_wdata = PW'(POOL_PAGES - 1) - clr_ix;
      end
      S_EXEC: begin
        unique case (req_op)
          OP_UPDATE: begin
            ent_we    = hit;
            ent_waddr = ent_addr(cur, idx);
          end
          OP_INSERT: begin
            if (!hit && room_valid) begin
              ent_we    = 1'b1;
              ent_waddr = ent_addr(room_pg, room_fill);
              pg_we     = 1'b1;
              pg_waddr  = room_pg;
              pg_wdata  = {FW'(room_fill + 1'b1), room_next};
            end
          end
          OP_REMOVE: begin
            ent_raddr = ent_addr(cur, lastix);
          end
          default: begin
          end
        endcase
      end
      S_POP: begin
        ent_we    = 1'b1;
        ent_waddr = ent_addr(fr_rdata, FW'(0));
        pg_we     = 1'b1;
        pg_waddr  = fr_rdata;
        pg_wdata  = {FW'(1), NO_LINK};
      end
      S_LINK: begin
        pg_we    = 1'b1;
        pg_waddr = prev_pg;
        pg_wdata = {prev_fill, NW'(new_pg)};
      end
      S_MOVE: begin
        ent_we    = 1'b1;
        ent_waddr = ent_addr(cur, idx);
        ent_wdata = ent_rdata;
      end
      S_RMV: begin
        pg_we    = 1'b1;
        pg_waddr = cur;
        pg_wdata = {lastix, unlink ? NO_LINK : cur_next};
      end
      S_UNLINK: begin
        pg_we    = 1'b1;
        pg_waddr = prev_pg;
        pg_wdata = {prev_fill, cur_next};
        fr_we    = (free_top < NW'(POOL_PAGES));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_ix      <= '0;
      free_top    <= NW'(FREE_INIT);
      stored      <= '0;
      out_valid   <= 1'b0;
      num_buckets <= BUCKET_COUNT_RST;
      page_cap    <= BUCKET_CAP_RST;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BUCKET_COUNT) num_buckets <= cfg_data[6:0];
        else if (cfg_index == CFG_BUCKET_CAP) page_cap <= cfg_data[3:0];
      end
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: clr_ix <= clr_ix + 1'b1;
        S_EXEC: begin
          if (req_op == OP_INSERT && !hit && room_valid) stored <= stored + 12'd1;
        end
        S_POP: begin
          free_top <= ft_dec;
          stored   <= stored + 12'd1;
        end
        S_RMV: stored <= stored - 12'd1;
        S_UNLINK: begin
          if (free_top < NW'(POOL_PAGES)) free_top <= free_top + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        req_op  <= op_t'(opcode);
        req_key <= key;
        req_rec <= {rec_page, rec_slot};
      end
      S_HASH: begin
        hash       <= req_key * HASH_MUL;
        res_status <= ST_INVALID;
      end
      S_MOD: begin
        cur        <= PW'(mod_rem);
        room_valid <= 1'b0;
        prev_valid <= 1'b0;
        hit        <= 1'b0;
      end
      S_PG_WT: begin
        cur_fill <= pg_rfill;
        cur_next <= pg_rnext;
        idx      <= '0;
        if (!room_valid && pg_rfill < ucap) begin
          room_valid <= 1'b1;
          room_pg    <= cur;
          room_fill  <= pg_rfill;
          room_next  <= pg_rnext;
        end
      end
      S_ENT_CMP: begin
        if (ent_rdata[79:48] == req_key) begin
          hit     <= 1'b1;
          hit_rec <= ent_rdata[47:0];
        end else begin
          idx <= idx + 1'b1;
        end
      end
      S_PG_END: begin
        prev_valid <= 1'b1;
        prev_pg    <= cur;
        prev_fill  <= cur_fill;
        cur        <= cur_next[PW-1:0];
      end
      S_EXEC: begin
        unique case (req_op)
          OP_INSERT: begin
            if (hit) res_status <= ST_DUPLICATE;
            else if (room_valid || free_top != '0) res_status <= ST_OK;
            else res_status <= ST_NO_FREE;
          end
          default: res_status <= hit ? ST_OK : ST_NOT_FOUND;
        endcase
      end
      S_POP: new_pg <= fr_rdata;
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          status        <= res_status;
          total_entries <= stored;
          if (req_op == OP_SEARCH && res_status == ST_OK) begin
            found_page <= hit_rec[47:16];
            found_slot <= hit_rec[15:0];
          end else begin
            found_page <= '0;
            found_slot <= '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  `CPHI_ASSERT_IMP(a_free_bound, clk, rst, 1'b1, free_top <= NW'(FREE_INIT), "free stack too big")
  `CPHI_ASSERT_IMP(a_unlink_prev, clk, rst, state == S_UNLINK, prev_valid, "unlink without prev")
  `CPHI_ASSERT_IMP(a_cmp_idx, clk, rst, state == S_ENT_CMP, idx < cur_fill, "index beyond fill")
  `CPHI_ASSERT_IMP(a_mod_rem, clk, rst, mod_done, mod_rem < ubkt, "bucket out of range")
  `CPHI_ASSERT_NXT(a_done_out, clk, rst, state == S_DONE && (!out_valid || !out_stall), out_valid, "result lost")
endmodule

// ===== tb/chained_page_hash_index_checker.sv =====
// Checker of the hash index: predicts every reply and compares the replies the core returns.
`timescale 1ns / 100ps

module chained_page_hash_index_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [1:0]                      opcode,
  input  logic signed [31:0]              key,
  input  logic [31:0]                     rec_page,
  input  logic [15:0]                     rec_slot,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [2:0]                      status,
  input  logic [31:0]                     found_page,
  input  logic [15:0]                     found_slot,
  input  logic [11:0]                     total_entries,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [cphi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cphi_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending
);
  import cphi_pkg::*;

  localparam int NB_MAX  = DEF_MAX_BUCKETS;
  localparam int PE_MAX  = DEF_MAX_PAGE_ENTRIES;
  localparam int POOL    = DEF_POOL_PAGES;
  localparam int NUM_PRI = (NB_MAX < POOL) ? NB_MAX : POOL;
  localparam int NO_LINK = POOL;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] page;
    logic [15:0] slot;
    logic [11:0] total;
  } reply_t;

  reply_t      expected_replies[$];
  logic [6:0]  num_buckets;
  logic [3:0]  bucket_cap;
  logic [31:0] entry_key[POOL*PE_MAX];
  logic [47:0] entry_rec[POOL*PE_MAX];
  int          page_fill[POOL];
  int          page_next[POOL];
  int          free_stack[POOL];
  int          free_top;
  int          stored;

  assign pending = expected_replies.size();

  function automatic int home_page(input logic [31:0] k);
    logic [31:0] h;
    int nb;
    h = k * HASH_MUL;
    nb = num_buckets;
    if (nb < 1) nb = 1;
    if (nb > NUM_PRI) nb = NUM_PRI;
    return int'(h % nb);
  endfunction

  function automatic bit find_key(input logic [31:0] k, output int pg, output int ix,
                                  output int prev);
    int p;
    int prev_page;
    int n;
    p = home_page(k);
    prev_page = NO_LINK;
    for (int s = 0; s < POOL && p < POOL; s++) begin
      n = page_fill[p];
      if (n > PE_MAX) n = PE_MAX;
      for (int i = 0; i < n; i++) begin
        if (entry_key[p*PE_MAX+i] == k) begin
          pg = p;
          ix = i;
          prev = prev_page;
          return 1'b1;
        end
      end
      prev_page = p;
      p = page_next[p];
    end
    return 1'b0;
  endfunction

  function automatic logic [2:0] insert_key(input logic [31:0] k, input logic [47:0] r);
    int pg, ix, prev, p, last, cap, np, e;
    if (find_key(k, pg, ix, prev)) return ST_DUPLICATE;
    cap = bucket_cap;
    if (cap < 1) cap = 1;
    if (cap > PE_MAX) cap = PE_MAX;
    p = home_page(k);
    last = p;
    for (int s = 0; s < POOL && p < POOL; s++) begin
      if (page_fill[p] < cap) begin
        e = p * PE_MAX + page_fill[p];
        entry_key[e] = k;
        entry_rec[e] = r;
        page_fill[p]++;
        stored++;
        return ST_OK;
      end
      last = p;
      p = page_next[p];
    end
    if (free_top == 0) return ST_NO_FREE;
    free_top--;
    np = free_stack[free_top];
    if (np >= POOL || last >= POOL) return ST_NO_FREE;
    entry_key[np*PE_MAX] = k;
    entry_rec[np*PE_MAX] = r;
    page_fill[np] = 1;
    page_next[np] = NO_LINK;
    page_next[last] = np;
    stored++;
    return ST_OK;
  endfunction

  function automatic logic [2:0] remove_key(input logic [31:0] k);
    int pg, ix, prev, lastix, base;
    if (!find_key(k, pg, ix, prev)) return ST_NOT_FOUND;
    base = pg * PE_MAX;
    lastix = page_fill[pg] - 1;
    if (ix != lastix) begin
      entry_key[base+ix] = entry_key[base+lastix];
      entry_rec[base+ix] = entry_rec[base+lastix];
    end
    page_fill[pg] = lastix;
    stored--;
    if (lastix == 0 && prev < POOL) begin
      page_next[prev] = page_next[pg];
      page_next[pg] = NO_LINK;
      if (free_top < POOL) begin
        free_stack[free_top] = pg;
        free_top++;
      end
    end
    return ST_OK;
  endfunction

  function automatic reply_t compute_reply(input op_t op, input logic [31:0] k,
                                           input logic [31:0] rp, input logic [15:0] rs);
    reply_t res;
    int pg, ix, prev;
    logic valid_rec;
    res = '0;
    valid_rec = (rp != 32'hFFFF_FFFF);
    case (op)
      OP_SEARCH: begin
        if (find_key(k, pg, ix, prev)) begin
          res.page = entry_rec[pg*PE_MAX+ix][47:16];
          res.slot = entry_rec[pg*PE_MAX+ix][15:0];
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      OP_INSERT: res.status = valid_rec ? insert_key(k, {rp, rs}) : ST_INVALID;
      OP_REMOVE: res.status = remove_key(k);
      default: begin
        if (!valid_rec) res.status = ST_INVALID;
        else if (find_key(k, pg, ix, prev)) entry_rec[pg*PE_MAX+ix] = {rp, rs};
        else res.status = ST_NOT_FOUND;
      end
    endcase
    res.total = stored[11:0];
    return res;
  endfunction

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst) begin
      num_buckets = BUCKET_COUNT_RST;
      bucket_cap = BUCKET_CAP_RST;
      for (int i = 0; i < POOL; i++) begin
        page_fill[i] = 0;
        page_next[i] = NO_LINK;
      end
      free_top = 0;
      for (int i = POOL; i > NUM_PRI; i--) begin
        free_stack[free_top] = i - 1;
        free_top++;
      end
      stored = 0;
      expected_replies.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BUCKET_COUNT) num_buckets = cfg_data[6:0];
        else if (cfg_index == CFG_BUCKET_CAP) bucket_cap = cfg_data[3:0];
      end
      if (out_valid && !out_stall) begin
        got = '{status, found_page, found_slot, total_entries};
        if (expected_replies.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected reply %h", got);
        end else begin
          want = expected_replies.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: status %0d/%0d page %h/%h slot %h/%h total %0d/%0d",
                       want.status, got.status, want.page, got.page,
                       want.slot, got.slot, want.total, got.total);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_replies.push_back(compute_reply(op_t'(opcode), key, rec_page, rec_slot));
    end
  end

endmodule

// ===== tb/tb_chained_page_hash_index_core.sv =====
// Testbench top of the hash index: drives requests and registers and reports the verdict.
`timescale 1ns / 100ps

module tb_chained_page_hash_index_core;
  import cphi_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            opcode;
  logic signed [31:0]    key;
  logic [31:0]           rec_page;
  logic [15:0]           rec_slot;
  logic                  out_valid;
  logic                  out_stall;
  logic [2:0]            status;
  logic [31:0]           found_page;
  logic [15:0]           found_slot;
  logic [11:0]           total_entries;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;
  int                    idle_cycles;
  logic [31:0]           key_pool[48];

  chained_page_hash_index_core i_dut (.*);

  chained_page_hash_index_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(input op_t op, input logic [31:0] k,
                              input logic [31:0] rp, input logic [15:0] rs);
    int gap;
    in_valid <= 1'b1;
    opcode <= op;
    key <= k;
    rec_page <= rp;
    rec_slot <= rs;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    gap = random_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_requests(input int count);
    op_t op;
    logic [31:0] k;
    logic [31:0] rp;
    int r;
    for (int n = 0; n < count; n++) begin
      op = op_t'($urandom_range(0, 3));
      k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 47)] : $urandom;
      r = $urandom_range(0, 15);
      rp = (r == 0) ? 32'hFFFF_FFFF : (r == 1) ? 32'h0 : $urandom;
      send_request(op, k, rp, 16'($urandom));
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    opcode <= OP_SEARCH;
    key <= '0;
    rec_page <= '0;
    rec_slot <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 48; i++) key_pool[i] = $urandom;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_request(OP_SEARCH, 32'h8000_0000, 32'h0, 16'h0);
    send_request(OP_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(OP_INSERT, 32'h8000_0000, 32'hFFFF_FFFE, 16'hFFFF);
    send_request(OP_INSERT, 32'h7FFF_FFFF, 32'h0, 16'h0);
    send_request(OP_INSERT, 32'h0, 32'h1234_5678, 16'h00FF);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hAAAA_5555, 16'hA5A5);
    send_request(OP_INSERT, 32'h0, 32'h1, 16'h1);
    send_request(OP_SEARCH, 32'h8000_0000, 32'h0, 16'h0);
    send_request(OP_SEARCH, 32'h7FFF_FFFF, 32'h0, 16'h0);
    send_request(OP_UPDATE, 32'h0, 32'hFFFF_FFFF, 16'h0);
    send_request(OP_UPDATE, 32'h1357_9BDF, 32'h5, 16'h5);
    send_request(OP_UPDATE, 32'h0, 32'h5555_AAAA, 16'h5A5A);
    send_request(OP_SEARCH, 32'h0, 32'h0, 16'h0);
    send_request(OP_REMOVE, 32'h1357_9BDF, 32'h0, 16'h0);
    send_request(OP_REMOVE, 32'h7FFF_FFFF, 32'h0, 16'h0);
    send_request(OP_SEARCH, 32'h7FFF_FFFF, 32'h0, 16'h0);
    send_request(OP_SEARCH, 32'hFFFF_FFFF, 32'h0, 16'h0);
    drain();

    write_reg(CFG_BUCKET_COUNT, 8'd1);
    write_reg(CFG_BUCKET_CAP, 8'd2);
    for (int i = 0; i < 5; i++) send_request(OP_INSERT, key_pool[i+4], $urandom, 16'($urandom));
    send_request(OP_REMOVE, key_pool[8], 32'h0, 16'h0);
    send_request(OP_REMOVE, key_pool[4], 32'h0, 16'h0);
    send_request(OP_SEARCH, key_pool[7], 32'h0, 16'h0);
    drain();

    write_reg(CFG_BUCKET_COUNT, 8'hFF);
    write_reg(CFG_BUCKET_CAP, 8'hFF);
    write_reg(2'd2, 8'h55);
    write_reg(2'd3, 8'hAA);
    random_requests(250);
    drain();

    write_reg(CFG_BUCKET_COUNT, 8'd3);
    write_reg(CFG_BUCKET_CAP, 8'd2);
    random_requests(250);
    drain();

    write_reg(CFG_BUCKET_COUNT, 8'd0);
    write_reg(CFG_BUCKET_CAP, 8'd0);
    random_requests(200);
    drain();

    write_reg(CFG_BUCKET_COUNT, 8'd40);
    write_reg(CFG_BUCKET_CAP, 8'd5);
    random_requests(180);
    drain();

    // Fill one bucket with single-entry pages until the free page stack runs dry.
    write_reg(CFG_BUCKET_COUNT, 8'd1);
    write_reg(CFG_BUCKET_CAP, 8'd1);
    for (int i = 0; i < 200; i++) send_request(OP_INSERT, $urandom, $urandom, 16'($urandom));
    random_requests(20);
    drain();
    repeat (50) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("tb_chained_page_hash_index_core OK");
    end else begin
      $display("tb_chained_page_hash_index_core NOT OK");
    end
    $finish;
  end

  initial begin
    forever begin
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_stall <= 1'b0;
        n = $urandom_range(1, 20);
      end else if (r < 90) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 3);
      end else begin
        out_stall <= 1'b1;
        n = $urandom_range(20, 60);
      end
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_chained_page_hash_index_core NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
